// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the ramp/soak sequencer.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is high.
`define RSS_ASSERT(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define RSS_ASSERT_ALWAYS(name, clock, prop, msg) \
  name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/rss_pkg.sv -----
// Types and constants for the ramp/soak profile sequencer.
// No dependencies; used by every module of the block.
package rss_pkg;

  localparam int unsigned MAX_STEPS_DEF = 8;

  // Time base and setpoint arithmetic
  localparam logic [31:0] MS_PER_MIN     = 32'd60000;
  // Quotients at or above 2^16 always clamp, so the product saturates there.
  localparam logic [47:0] SAT_LIMIT      = 48'(65536) * 48'(MS_PER_MIN);
  // floor(x / 1875) = (x * RECIP_M) >> RECIP_SHIFT for any 27-bit x
  localparam logic [27:0] RECIP_M        = 28'd146601551;
  localparam int unsigned RECIP_SHIFT    = 38;
  localparam int unsigned QUOT_W         = 17;
  localparam logic [QUOT_W-1:0] QUOT_SAT = 17'h10000;

  // Register reset values
  localparam logic [3:0]  STEPS_TOTAL_RST = 4'd1;
  localparam logic [15:0] INTERVAL_RST    = 16'd1000;

  // Stream field layout
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_LOAD  = 2'd2
  } action_t;

  typedef enum logic {
    REG_STEPS_TOTAL = 1'b0,
    REG_INTERVAL    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    SP_NONE   = 2'd0,
    SP_TARGET = 2'd1,
    SP_RAMP   = 2'd2
  } sp_kind_t;

  // One step of the program as held in the step table
  typedef struct packed {
    logic [11:0] target;      // whole degrees
    logic [15:0] rate;        // 1/16 degree per minute
    logic [31:0] soak_limit;  // (soak minutes + 1) * 60000 ms
  } step_entry_t;

  // Request handed from the sequencer to the setpoint pipeline
  typedef struct packed {
    sp_kind_t    kind;
    logic [31:0] elapsed;
    logic [15:0] rate;
    logic [15:0] base;
    logic [15:0] target16;
    logic        done_event;
    logic        program_done;
    logic [2:0]  step_now;
    logic        phase_now;
  } sp_req_t;

endpackage

// ----- rtl/ramp_soak_profile_sequencer.sv -----
// A request passes four register stages before its result is offered. The block
// takes one request per cycle while the setpoint pipeline can advance, which it
// does whenever the result register is free.
// Reset (rst, synchronous): program idle and finished, step 0 in ramp,
// timestamps cleared, registers to defaults; the step table keeps its contents.
// Depends on rss_pkg, rss_step_table, rss_setpoint_pipe and assert_macros.svh.
module ramp_soak_profile_sequencer #(
  parameter int unsigned MAX_STEPS = rss_pkg::MAX_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [31:0] now_ms, [47:32] curr_temp, [50:48] load_index,
  // [62:51] load_target, [78:63] load_rate, [94:79] load_soak_min, [95] zero
  input  logic [rss_pkg::S_TDATA_W-1:0]   s_tdata,
  // [1:0] action
  input  logic [1:0]                      s_tuser,
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] setpoint, [16] done_event, [17] program_done, [20:18] step_now,
  // [21] phase_now, [23:22] zero
  output logic [rss_pkg::M_TDATA_W-1:0]   m_tdata,
  // [0] setpoint_valid
  output logic                            m_tuser,
  // Configuration writes
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [15:0]                     cfg_data
);
  import rss_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  // Request fields
  action_t     action;
  logic [31:0] now_ms;
  logic [15:0] curr_temp;
  logic [2:0]  load_index;
  logic [11:0] load_target;
  logic [15:0] load_rate;
  logic [15:0] load_soak_min;

  assign action        = action_t'(s_tuser);
  assign now_ms        = s_tdata[31:0];
  assign curr_temp     = s_tdata[47:32];
  assign load_index    = s_tdata[50:48];
  assign load_target   = s_tdata[62:51];
  assign load_rate     = s_tdata[78:63];
  assign load_soak_min = s_tdata[94:79];

  // Configuration registers
  logic [3:0]  steps_total;
  logic [15:0] interval_ms;

  // Sequencer state
  logic [IDX_W-1:0] step_index, step_index_next;
  logic             in_soak, in_soak_next;
  logic             finished, finished_next;
  logic [31:0]      step_start_ms, step_start_ms_next;
  logic [15:0]      step_start_temp, step_start_temp_next;
  logic [31:0]      last_update_ms, last_update_ms_next;

  // Step table
  logic        tbl_we;
  step_entry_t tbl_wdata;
  step_entry_t cur_step;
  logic [16:0] soak_plus;

  // Per-request decisions
  logic        accept;
  logic        req_ready;
  sp_req_t     req;
  logic [31:0] since_start;
  logic [31:0] since_update;
  logic        soak_over;
  logic        interval_over;
  logic        at_target;
  logic        more_steps;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_total <= STEPS_TOTAL_RST;
      interval_ms <= INTERVAL_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_STEPS_TOTAL: steps_total <= cfg_data[3:0];
        REG_INTERVAL:    interval_ms <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Hold the soak time as an end-of-soak threshold in ms, so a tick only
  // compares: minutes elapsed exceed soak exactly when ms >= (soak+1)*60000.
  assign soak_plus = {1'b0, load_soak_min} + 17'd1;

  always_comb begin
    tbl_wdata.target     = load_target;
    tbl_wdata.rate       = load_rate;
    tbl_wdata.soak_limit = 32'(soak_plus) * MS_PER_MIN;
  end

  // The table is read at the next step index, so cur_step always mirrors
  // the entry of the step in force.
  rss_step_table #(
    .MAX_STEPS (MAX_STEPS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (IDX_W'(load_index)),
    .wr_data (tbl_wdata),
    .rd_addr (step_index_next),
    .rd_data (cur_step)
  );

  assign since_start   = now_ms - step_start_ms;
  assign since_update  = now_ms - last_update_ms;
  assign soak_over     = (since_start >= cur_step.soak_limit);
  assign interval_over = (since_update > {16'd0, interval_ms});
  assign at_target     = (curr_temp[15:4] >= cur_step.target);
  // A step count of zero behaves as one; counts beyond the table are capped.
  assign more_steps    = ((32'(step_index) + 32'd1) < 32'(steps_total)) &&
                         ((32'(step_index) + 32'd1) < MAX_STEPS);

  always_comb begin
    step_index_next      = step_index;
    in_soak_next         = in_soak;
    finished_next        = finished;
    step_start_ms_next   = step_start_ms;
    step_start_temp_next = step_start_temp;
    last_update_ms_next  = last_update_ms;
    tbl_we               = 1'b0;

    req.kind       = SP_NONE;
    req.elapsed    = since_start;
    req.rate       = cur_step.rate;
    req.base       = step_start_temp;
    req.target16   = {cur_step.target, 4'd0};
    req.done_event = 1'b0;

    if (accept) begin
      unique case (action)
        ACT_LOAD: begin
          // Drop loads that fall outside the table.
          tbl_we = (32'(load_index) < MAX_STEPS);
        end
        ACT_START: begin
          step_index_next      = '0;
          finished_next        = 1'b0;
          in_soak_next         = 1'b0;
          step_start_temp_next = curr_temp;
          step_start_ms_next   = now_ms;
          last_update_ms_next  = now_ms;
        end
        ACT_TICK: begin
          if (!finished) begin
            if (in_soak) begin
              if (soak_over) begin
                if (more_steps) begin
                  // Advance to the next step and ramp from where we stand.
                  step_index_next      = step_index + IDX_W'(1);
                  in_soak_next         = 1'b0;
                  step_start_temp_next = curr_temp;
                  step_start_ms_next   = now_ms;
                  last_update_ms_next  = now_ms;
                end else begin
                  finished_next  = 1'b1;
                  req.done_event = 1'b1;
                end
              end
            end else if (interval_over) begin
              if (at_target) begin
                // Target reached: enter soak and issue the target itself.
                in_soak_next       = 1'b1;
                step_start_ms_next = now_ms;
                req.kind           = SP_TARGET;
              end else begin
                req.kind            = SP_RAMP;
                last_update_ms_next = now_ms;
              end
            end
          end
        end
        default: ;
      endcase
    end

    req.program_done = finished_next;
    req.step_now     = 3'(step_index_next);
    req.phase_now    = in_soak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index      <= '0;
      in_soak         <= 1'b0;
      finished        <= 1'b1;
      step_start_ms   <= '0;
      step_start_temp <= '0;
      last_update_ms  <= '0;
    end else begin
      step_index      <= step_index_next;
      in_soak         <= in_soak_next;
      finished        <= finished_next;
      step_start_ms   <= step_start_ms_next;
      step_start_temp <= step_start_temp_next;
      last_update_ms  <= last_update_ms_next;
    end
  end

  // Setpoint arithmetic runs behind the state update; results stay in order.
  rss_setpoint_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .req_valid (accept),
    .req_ready (req_ready),
    .req       (req),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  `RSS_ASSERT(a_sp_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata[15:0] == '0, "stray setpoint")
  `RSS_ASSERT(a_sp_running, clk, rst, m_tvalid && m_tuser |-> !m_tdata[17], "setpoint when idle")
  `RSS_ASSERT(a_done_flag, clk, rst, m_tvalid && m_tdata[16] |-> m_tdata[17], "done, not finished")
  `RSS_ASSERT(a_stall_cause, clk, rst, !s_tready |-> m_tvalid && !m_tready, "request stalled")

endmodule

// ----- rtl/rss_step_table.sv -----
// Step table of the ramp/soak sequencer: one write port, one registered read.
// Depends on rss_pkg.
module rss_step_table #(
  parameter int unsigned MAX_STEPS = rss_pkg::MAX_STEPS_DEF,
  parameter int unsigned IDX_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  rss_pkg::step_entry_t wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output rss_pkg::step_entry_t rd_data
);
  import rss_pkg::*;

  step_entry_t mem [MAX_STEPS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Pass a write straight through when it hits the entry being read.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rss_setpoint_pipe.sv -----
// Four-stage setpoint pipeline: request capture, ramp product, divide by 60000, clamp and result.
// Depends on rss_pkg.
module rss_setpoint_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  rss_pkg::sp_req_t     req,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [rss_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser
);
  import rss_pkg::*;

  logic        va, vb, vc;
  logic        adv_a, adv_b, adv_c, adv_d;
  sp_req_t     ra, rb, rc;
  logic [47:0] prod_b;
  logic        sat_c;
  logic [54:0] recip_c;

  logic [QUOT_W-1:0] quot;
  logic [17:0]       ramp_sum;
  logic [15:0]       sp_value;
  logic              sp_valid;

  assign adv_d     = !m_tvalid || m_tready;
  assign adv_c     = !vc || adv_d;
  assign adv_b     = !vb || adv_c;
  assign adv_a     = !va || adv_b;
  assign req_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv_a) va       <= req_valid;
      if (adv_b) vb       <= va;
      if (adv_c) vc       <= vb;
      if (adv_d) m_tvalid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      ra <= req;
    end
    if (adv_b) begin
      rb     <= ra;
      prod_b <= 48'(ra.elapsed) * 48'(ra.rate);
    end
    if (adv_c) begin
      rc      <= rb;
      sat_c   <= (prod_b >= SAT_LIMIT);
      recip_c <= 55'(prod_b[31:5]) * 55'(RECIP_M);
    end
  end

  always_comb begin
    quot     = sat_c ? QUOT_SAT : recip_c[RECIP_SHIFT +: QUOT_W];
    ramp_sum = 18'(rc.base) + 18'(quot);
    sp_valid = 1'b0;
    sp_value = 16'd0;
    case (rc.kind)
      SP_TARGET: begin
        sp_valid = 1'b1;
        sp_value = rc.target16;
      end
      SP_RAMP: begin
        sp_valid = 1'b1;
        sp_value = (ramp_sum > 18'(rc.target16)) ? rc.target16 : ramp_sum[15:0];
      end
      default: begin
        sp_valid = 1'b0;
        sp_value = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      m_tuser <= sp_valid;
      m_tdata <= {2'b00, rc.phase_now, rc.step_now, rc.program_done,
                  rc.done_event, sp_value};
    end
  end

endmodule

// ----- sim/ramp_soak_profile_checker.sv -----
`timescale 1ns / 100ps
// Checker for the ramp/soak profile sequencer. It mirrors the program state
// from the requests and register writes it sees, and checks every result.
// Depends on rss_pkg for the stream layout, action codes and register indexes.
module ramp_soak_profile_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // [31:0] now_ms, [47:32] curr_temp, [50:48] load_index,
  // [62:51] load_target, [78:63] load_rate, [94:79] load_soak_min, [95] zero
  input  logic [rss_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] action
  input  logic [1:0]                    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // [15:0] setpoint, [16] done_event, [17] program_done, [20:18] step_now,
  // [21] phase_now, [23:22] zero
  input  logic [rss_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] setpoint_valid
  input  logic                          m_tuser,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            errors,
  output int                            outstanding,
  output int                            checked,
  output int                            setpoints,
  output int                            completions
);
  import rss_pkg::*;

  typedef struct packed {
    logic        sp_valid;
    logic [15:0] setpoint;
    logic        done_event;
    logic        program_done;
    logic [2:0]  step_now;
    logic        phase_now;
  } profile_status_t;

  // Register copies
  logic [3:0]  steps_total;
  logic [15:0] interval_ms;

  // Program state
  logic [2:0]  cur_step;
  logic        soaking;
  logic        finished;
  logic [31:0] step_t0_ms;
  logic [31:0] last_upd_ms;
  logic [15:0] step_t0_temp;
  logic [11:0] target_tbl [MAX_STEPS_DEF];
  logic [15:0] rate_tbl   [MAX_STEPS_DEF];
  logic [15:0] soak_tbl   [MAX_STEPS_DEF];

  profile_status_t status_due [$];
  profile_status_t predicted;
  profile_status_t observed;

  task automatic advance_profile(input logic [1:0] act, input logic [S_TDATA_W-1:0] req,
                                 output profile_status_t res);
    logic [31:0] now_ms;
    logic [31:0] since_ms;
    logic [15:0] temp;
    logic [15:0] tgt16;
    logic [2:0]  idx;
    logic [3:0]  in_use;
    logic [63:0] ramp;
    now_ms = req[31:0];
    temp   = req[47:32];
    idx    = req[50:48];
    res    = '0;
    case (act)
      ACT_LOAD: begin
        target_tbl[idx] = req[62:51];
        rate_tbl[idx]   = req[78:63];
        soak_tbl[idx]   = req[94:79];
      end
      ACT_START: begin
        cur_step     = '0;
        finished     = 1'b0;
        soaking      = 1'b0;
        step_t0_ms   = now_ms;
        last_upd_ms  = now_ms;
        step_t0_temp = temp;
      end
      ACT_TICK: if (!finished) begin
        tgt16 = {target_tbl[cur_step], 4'b0000};
        if (soaking) begin
          since_ms = now_ms - step_t0_ms;
          if (since_ms / MS_PER_MIN > 32'(soak_tbl[cur_step])) begin
            in_use = (steps_total > MAX_STEPS_DEF) ? 4'(MAX_STEPS_DEF) : steps_total;
            if (4'(cur_step) + 4'd1 < in_use) begin
              cur_step     = cur_step + 3'd1;
              soaking      = 1'b0;
              step_t0_ms   = now_ms;
              last_upd_ms  = now_ms;
              step_t0_temp = temp;
            end else begin
              finished       = 1'b1;
              res.done_event = 1'b1;
            end
          end
        end else begin
          since_ms = now_ms - last_upd_ms;
          if (since_ms > 32'(interval_ms)) begin
            res.sp_valid = 1'b1;
            if (temp[15:4] >= target_tbl[cur_step]) begin
              soaking      = 1'b1;
              step_t0_ms   = now_ms;
              res.setpoint = tgt16;
            end else begin
              since_ms = now_ms - step_t0_ms;
              ramp = 64'(step_t0_temp)
                   + (64'(since_ms) * 64'(rate_tbl[cur_step])) / 64'(MS_PER_MIN);
              if (ramp > 64'(tgt16)) ramp = 64'(tgt16);
              res.setpoint = ramp[15:0];
              last_upd_ms  = now_ms;
            end
          end
        end
      end
      default: ;
    endcase
    res.program_done = finished;
    res.step_now     = cur_step;
    res.phase_now    = soaking;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      steps_total  = STEPS_TOTAL_RST;
      interval_ms  = INTERVAL_RST;
      cur_step     = '0;
      soaking      = 1'b0;
      finished     = 1'b1;
      step_t0_ms   = '0;
      last_upd_ms  = '0;
      step_t0_temp = '0;
      status_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        observed.sp_valid     = m_tuser;
        observed.setpoint     = m_tdata[15:0];
        observed.done_event   = m_tdata[16];
        observed.program_done = m_tdata[17];
        observed.step_now     = m_tdata[20:18];
        observed.phase_now    = m_tdata[21];
        if (status_due.size() == 0) begin
          $error("result with no request waiting: tdata %h tuser %b", m_tdata, m_tuser);
          errors++;
        end else begin
          predicted = status_due.pop_front();
          compare_field("setpoint_valid", predicted.sp_valid, observed.sp_valid);
          compare_field("setpoint", predicted.setpoint, observed.setpoint);
          compare_field("done_event", predicted.done_event, observed.done_event);
          compare_field("program_done", predicted.program_done, observed.program_done);
          compare_field("step_now", predicted.step_now, observed.step_now);
          compare_field("phase_now", predicted.phase_now, observed.phase_now);
          checked++;
          if (predicted.sp_valid) setpoints++;
          if (predicted.done_event) completions++;
        end
      end
      if (s_tvalid && s_tready) begin
        advance_profile(s_tuser, s_tdata, predicted);
        status_due.push_back(predicted);
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_STEPS_TOTAL) steps_total = cfg_data[3:0];
        else interval_ms = cfg_data;
      end
    end
    outstanding = status_due.size();
  end

endmodule

// ----- sim/ramp_soak_profile_sequencer_tb.sv -----
`timescale 1ns / 100ps
// Top of the ramp/soak sequencer testbench: clock, reset, register writes,
// request stimulus and verdict. Depends on rss_pkg, the sequencer RTL and
// ramp_soak_profile_checker, which does all prediction and comparison.
module ramp_soak_profile_sequencer_tb;
  import rss_pkg::*;

  localparam int unsigned SEG_COUNT    = 6;
  localparam int unsigned SEG_REQUESTS = 124;
  // Four register stages from request to result
  localparam int unsigned LATENCY      = 4;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;
  // The one action code the block leaves unused
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  // [31:0] now_ms, [47:32] curr_temp, [50:48] load_index,
  // [62:51] load_target, [78:63] load_rate, [94:79] load_soak_min, [95] zero
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  // [1:0] action
  logic [1:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  // [15:0] setpoint, [16] done_event, [17] program_done, [20:18] step_now,
  // [21] phase_now, [23:22] zero
  logic [M_TDATA_W-1:0] m_tdata;
  // [0] setpoint_valid
  logic                 m_tuser;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [15:0]          cfg_data  = '0;

  int errors;
  int outstanding;
  int checked;
  int setpoints;
  int completions;

  // Idling odds in percent, per side
  int unsigned src_idle  = 35;
  int unsigned sink_idle = 65;
  int unsigned requests_sent = 0;
  // Running timestamp of the stimulus, and the interval last written
  logic [31:0] clock_ms = '0;
  int unsigned interval_ms = INTERVAL_RST;

  ramp_soak_profile_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ramp_soak_profile_checker profile_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .outstanding(outstanding),
    .checked    (checked),
    .setpoints  (setpoints),
    .completions(completions)
  );

  always #4 clk = ~clk;

  // Stall the result side at random, one decision per cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle);
  end

  // Write one register; hold the enable for a single edge, then drop it
  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_INTERVAL) interval_ms = value;
    @(negedge clk);
  endtask

  // Offer one request after a random gap and hold it until it is taken.
  // Valid stays high on return so back-to-back requests need no toggle.
  task automatic push_req(input logic [1:0] act, input logic [31:0] at_ms,
                          input logic [15:0] temp, input logic [2:0] idx,
                          input logic [11:0] tgt, input logic [15:0] rate,
                          input logic [15:0] soak);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, soak, rate, tgt, idx, temp, at_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (act != ACT_UNUSED) requests_sent++;
  endtask

  // Ticks and starts carry random junk in the load fields
  task automatic send_tick(input logic [31:0] at_ms, input logic [15:0] temp);
    push_req(ACT_TICK, at_ms, temp, 3'($urandom), 12'($urandom), 16'($urandom),
             16'($urandom));
  endtask

  task automatic send_start(input logic [31:0] at_ms, input logic [15:0] temp);
    push_req(ACT_START, at_ms, temp, 3'($urandom), 12'($urandom), 16'($urandom),
             16'($urandom));
  endtask

  // Drop valid and wait until every result has been taken, plus the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    int unsigned seg;
    int unsigned goal;
    int unsigned pick;
    int unsigned delta;
    int unsigned temp_now;
    logic [31:0] t0;
    logic [31:0] soak1_ms;
    logic [31:0] soak2_ms;
    logic [3:0]  steps;
    logic [15:0] gap;

    // Hold reset, then release it on a falling edge
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- Directed part: two-step program under default-ish settings ----
    write_reg(REG_STEPS_TOTAL, 16'd2);
    write_reg(REG_INTERVAL, 16'd1000);

    // Idle tick before any start, then the unused action code
    send_tick(32'd0, 16'hFFFF);
    push_req(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 12'hFFF, 16'hFFFF, 16'hFFFF);

    // Fill the whole step table up front so no tick ever reads a blank entry
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd0, 12'd100, 16'd960, 16'd0);
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd1, 12'd4095, 16'hFFFF, 16'd0);
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd2, 12'd0, 16'd0, 16'hFFFF);
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd3, 12'd200, 16'd120, 16'd1);
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd4, 12'd50, 16'd16, 16'd2);
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd5, 12'd300, 16'd4000, 16'd0);
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd6, 12'd10, 16'd1, 16'd3);
    push_req(ACT_LOAD, 32'd0, 16'd0, 3'd7, 12'd1000, 16'd30000, 16'd1);

    // Start just short of the timestamp wrap so later updates wrap
    t0 = 32'hFFFF_FC00;
    send_start(t0, 16'd320);
    send_tick(t0 + 32'd1000, 16'd400);     // exactly one interval: no update
    send_tick(t0 + 32'd1001, 16'd400);     // first ramp setpoint, just short of the wrap
    send_tick(t0 + 32'd200000, 16'd500);   // ramp overshoots, clamp to target
    send_tick(t0 + 32'd201500, 16'd1600);  // target reached: enter soak
    soak1_ms = t0 + 32'd201500;
    send_tick(soak1_ms + 32'd59999, 16'd1600);  // soak not yet over
    send_tick(soak1_ms + 32'd60000, 16'hFFFF);  // advance to step 1
    send_tick(soak1_ms + 32'd61001, 16'hFFFF);  // full-scale target, soak at once
    soak2_ms = soak1_ms + 32'd61001;
    send_tick(soak2_ms + 32'd60000, 16'hFFFF);  // last step over: done pulse
    send_tick(soak2_ms + 32'd70000, 16'd0);     // idle after finishing
    send_start(soak2_ms + 32'd80000, 16'd0);
    send_tick(soak2_ms + 32'd81001, 16'd16);
    send_start(soak2_ms + 32'd82000, 16'd100);  // restart while ramping
    send_tick(soak2_ms + 32'd82000, 16'd100);   // zero time since update
    clock_ms = soak2_ms + 32'd82000;

    // ---- Random part: three idling patterns, two register settings each ----
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin src_idle = 35; sink_idle = 65; end
        1: begin src_idle = 65; sink_idle = 35; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      for (int half = 0; half < 2; half++) begin
        seg = mode * 2 + half;
        settle();
        // Walk the register extremes: zero and oversized step counts,
        // zero and full-scale intervals
        case (seg)
          0: begin steps = 4'd8;  gap = 16'd0;     end
          1: begin steps = 4'd0;  gap = 16'hFFFF;  end
          2: begin steps = 4'd15; gap = 16'd1000;  end
          3: begin steps = 4'd1;  gap = 16'($urandom_range(5000)); end
          4: begin steps = 4'($urandom_range(15)); gap = 16'd250; end
          default: begin steps = 4'd5; gap = 16'd1; end
        endcase
        write_reg(REG_STEPS_TOTAL, 16'(steps));
        write_reg(REG_INTERVAL, gap);

        goal = requests_sent + SEG_REQUESTS;
        while (requests_sent < goal) begin
          if ($urandom_range(99) < 10) begin
            // Noise: any action code with any field contents
            clock_ms = $urandom;
            push_req(2'($urandom_range(3)), clock_ms, 16'($urandom), 3'($urandom),
                     12'($urandom), 16'($urandom), 16'($urandom));
          end else begin
            // Well-formed run: reload a few steps, start, then a train of
            // ticks with the temperature climbing towards the targets
            repeat ($urandom_range(3)) begin
              push_req(ACT_LOAD, $urandom, 16'($urandom), 3'($urandom_range(7)),
                       ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(250)),
                       16'($urandom),
                       ($urandom_range(6) == 0) ? 16'($urandom) : 16'($urandom_range(3)));
            end
            temp_now = $urandom_range(800);
            clock_ms += $urandom_range(5000);
            send_start(clock_ms, 16'(temp_now));
            repeat ($urandom_range(8, 40)) begin
              // Mostly just past the interval or far enough to end a soak;
              // now and then a jump anywhere, wrap included
              pick = $urandom_range(99);
              if (pick < 10) delta = $urandom_range(interval_ms);
              else if (pick < 55) delta = interval_ms + $urandom_range(1, 3000);
              else if (pick < 90) delta = $urandom_range(30000, 250000);
              else delta = $urandom;
              if ($urandom_range(19) == 0) begin
                temp_now = $urandom_range(65535);
              end else begin
                temp_now += $urandom_range(600);
                if (temp_now > 65535) temp_now = 65535;
              end
              clock_ms += delta;
              send_tick(clock_ms, 16'(temp_now));
            end
          end
        end
      end
    end

    settle();
    repeat (2 * LATENCY) @(negedge clk);

    $display("Covered %0d requests over %0d register settings and three idling patterns.",
             requests_sent, SEG_COUNT + 1);
    $display("Checked %0d results: %0d setpoints issued, %0d programs completed.",
             checked, setpoints, completions);
    if (errors == 0 && outstanding == 0) begin
      $display("[ramp_soak_profile_sequencer] OK");
    end else begin
      $display("[ramp_soak_profile_sequencer] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("[ramp_soak_profile_sequencer] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rss_pkg.sv
rtl/rss_step_table.sv
rtl/rss_setpoint_pipe.sv
rtl/ramp_soak_profile_sequencer.sv
sim/ramp_soak_profile_checker.sv
sim/ramp_soak_profile_sequencer_tb.sv
